@@ sv/msgcr_pkg.sv @@
// Shared types and constants for the microphone gain and chunk RMS meter.
// No dependencies; used by every module of the block.
package msgcr_pkg;

  localparam int RAW_W      = 32;
  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 4;
  localparam int SQ_W       = 31;  // square of a saturated sample, at most 2**30
  localparam int SQ_SHIFT   = 30;  // log2 of the largest square
  localparam int FRAC_SHIFT = 16;  // sum is scaled by 65536 before the divide
  localparam int Q_W        = 47;  // quotient width: mean square * 65536 < 2**47
  localparam int ROOT_W     = 24;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int SQ_REM_W   = ROOT_W + 2;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic signed [RAW_W-1:0] SAT_MAX = 32'sd32767;
  localparam logic signed [RAW_W-1:0] SAT_MIN = -32'sd32768;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN = 1'b0,
    REG_MUTE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] gain;
    logic              mute;
  } cfg_t;

endpackage

@@ sv/mic_sample_gain_and_chunk_rms_top.sv @@
// Top level of the microphone gain stage with chunk RMS meter.
// Depends on msgcr_pkg, msgcr_front, msgcr_queue and msgcr_back.
//
// Usage:
//   Input side is a queue: drive raw_sample_i / last_in_chunk_i with push_i,
//   a word is taken at a clock edge with push_i high and full_o low.
//   Result side is a queue too: while empty_o is low the oldest result sits on
//   sample_out_o / rms_level_o / rms_valid_o; pop_i with empty_o low takes it.
//   Exactly one result comes out per input word, in order.
//   Configuration goes through cfg_valid_i / cfg_ready_o with cfg_index_i
//   (0 = gain shift, 1 = mute) and cfg_data_i; write it only while idle.
// Flow:
//   An ordinary sample passes the stage 1 register and the queue into the
//   result register; words stream at one per cycle while pop_i keeps the
//   result register free and no chunk end is in work. A word marked last
//   runs a bit-serial divide and a square root in the back end before it
//   leaves. Meanwhile the front end keeps accepting the next chunk until
//   the 4-entry queue and its own stage fill up.
// Reset clears the accumulator, the sample count, the configuration and all
// valid flags but rms_valid_o; empty_o rises and full_o falls at once.
// When the receiver holds off pop_i, the result holds, the back end stalls,
// and the queue fills until full_o pushes back on the sender.
module mic_sample_gain_and_chunk_rms_top #(
  parameter int MAX_CHUNK = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push_i,
  output logic                                   full_o,
  input  logic signed [msgcr_pkg::RAW_W-1:0]     raw_sample_i,
  input  logic                                   last_in_chunk_i,
  output logic                                   empty_o,
  input  logic                                   pop_i,
  output logic signed [msgcr_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic [msgcr_pkg::ROOT_W-1:0]           rms_level_o,
  output logic                                   rms_valid_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [msgcr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [msgcr_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  // Count range follows the chunk limit; each square is below 2**31.
  localparam int CNT_W   = $clog2(MAX_CHUNK + 1);
  localparam int SUM_W   = msgcr_pkg::SQ_SHIFT + CNT_W;
  localparam int ENTRY_W = msgcr_pkg::SAMPLE_W + 1 + SUM_W + CNT_W;

  msgcr_pkg::cfg_t cfg_q;

  logic                            fq_push, fq_full;
  logic [msgcr_pkg::SAMPLE_W-1:0]  fq_sample;
  logic                            fq_last;
  logic [SUM_W-1:0]                fq_sum;
  logic [CNT_W-1:0]                fq_count;
  logic [ENTRY_W-1:0]              fq_entry, bq_entry;
  logic                            bq_pop, bq_empty;
  logic [msgcr_pkg::SAMPLE_W-1:0]  bq_sample;
  logic                            bq_last;
  logic [SUM_W-1:0]                bq_sum;
  logic [CNT_W-1:0]                bq_count;

  // Registers accept a write every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (msgcr_pkg::cfg_reg_e'(cfg_index_i))
        msgcr_pkg::REG_GAIN: cfg_q.gain <= cfg_data_i[msgcr_pkg::GAIN_W-1:0];
        msgcr_pkg::REG_MUTE: cfg_q.mute <= cfg_data_i[0];
        default:             cfg_q      <= cfg_q;
      endcase
    end
  end

  msgcr_front #(
    .MAX_CHUNK (MAX_CHUNK),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .push_i          (push_i),
    .full_o          (full_o),
    .raw_sample_i    (raw_sample_i),
    .last_in_chunk_i (last_in_chunk_i),
    .q_push_o        (fq_push),
    .q_full_i        (fq_full),
    .q_sample_o      (fq_sample),
    .q_last_o        (fq_last),
    .q_sum_o         (fq_sum),
    .q_count_o       (fq_count)
  );

  // Pack one queue entry: sample, last flag, chunk sum and count snapshot.
  assign fq_entry = {fq_sample, fq_last, fq_sum, fq_count};

  msgcr_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .full_o  (fq_full),
    .data_i  (fq_entry),
    .pop_i   (bq_pop),
    .empty_o (bq_empty),
    .data_o  (bq_entry)
  );

  assign {bq_sample, bq_last, bq_sum, bq_count} = bq_entry;

  msgcr_back #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (bq_empty),
    .q_pop_o      (bq_pop),
    .q_sample_i   (bq_sample),
    .q_last_i     (bq_last),
    .q_sum_i      (bq_sum),
    .q_count_i    (bq_count),
    .pop_i        (pop_i),
    .empty_o      (empty_o),
    .sample_out_o (sample_out_o),
    .rms_level_o  (rms_level_o),
    .rms_valid_o  (rms_valid_o)
  );

endmodule

@@ sv/msgcr_front.sv @@
// Front end: gain, saturation, mute, and chunk square-sum accumulation.
// Depends on msgcr_pkg; feeds msgcr_queue.
module msgcr_front #(
  parameter int MAX_CHUNK = 4096,
  parameter int CNT_W     = 13,
  parameter int SUM_W     = 43
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  msgcr_pkg::cfg_t                    cfg_i,
  input  logic                               push_i,
  output logic                               full_o,
  input  logic signed [msgcr_pkg::RAW_W-1:0] raw_sample_i,
  input  logic                               last_in_chunk_i,
  output logic                               q_push_o,
  input  logic                               q_full_i,
  output logic [msgcr_pkg::SAMPLE_W-1:0]     q_sample_o,
  output logic                               q_last_o,
  output logic [SUM_W-1:0]                   q_sum_o,
  output logic [CNT_W-1:0]                   q_count_o
);

  logic signed [msgcr_pkg::RAW_W-1:0]    s_ext;
  logic signed [msgcr_pkg::RAW_W-1:0]    gained;
  logic signed [msgcr_pkg::SAMPLE_W-1:0] sat;
  logic                                  s1_adv;
  logic                                  s1_valid_q;
  logic signed [msgcr_pkg::SAMPLE_W-1:0] s1_sample_q;
  logic [msgcr_pkg::SAMPLE_W-1:0]        s1_out_q;
  logic                                  s1_last_q;
  logic [msgcr_pkg::SAMPLE_W-1:0]        mag;
  logic [2*msgcr_pkg::SAMPLE_W-1:0]      sq;
  logic                                  counting;
  logic [SUM_W-1:0]                      sum_q, sum_new;
  logic [CNT_W-1:0]                      cnt_q, cnt_new;

  // Stage 1: take the upper half word, apply gain, clamp and mute.
  assign s_ext  = {{16{raw_sample_i[31]}}, raw_sample_i[31:16]};
  assign gained = s_ext <<< cfg_i.gain;

  always_comb begin
    if (gained > msgcr_pkg::SAT_MAX) begin
      sat = msgcr_pkg::SAMPLE_W'(msgcr_pkg::SAT_MAX);
    end else if (gained < msgcr_pkg::SAT_MIN) begin
      sat = msgcr_pkg::SAMPLE_W'(msgcr_pkg::SAT_MIN);
    end else begin
      sat = gained[msgcr_pkg::SAMPLE_W-1:0];
    end
  end

  assign s1_adv   = !s1_valid_q || !q_full_i;
  assign full_o   = !s1_adv;
  assign q_push_o = s1_valid_q && !q_full_i;

  // Stage 2: square and accumulate while the word moves into the queue.
  assign mag = s1_sample_q[msgcr_pkg::SAMPLE_W-1] ? msgcr_pkg::SAMPLE_W'(-s1_sample_q)
                                                  : s1_sample_q;
  assign sq  = {16'b0, mag} * {16'b0, mag};

  assign counting = cnt_q < CNT_W'(MAX_CHUNK);
  assign sum_new  = counting ? sum_q + SUM_W'(sq[msgcr_pkg::SQ_W-1:0]) : sum_q;
  assign cnt_new  = counting ? cnt_q + CNT_W'(1) : cnt_q;

  assign q_sample_o = s1_out_q;
  assign q_last_o   = s1_last_q;
  assign q_sum_o    = sum_new;
  assign q_count_o  = cnt_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      sum_q      <= '0;
      cnt_q      <= '0;
    end else begin
      if (s1_adv) begin
        s1_valid_q <= push_i;
      end
      if (q_push_o) begin
        sum_q <= s1_last_q ? '0 : sum_new;
        cnt_q <= s1_last_q ? '0 : cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && push_i) begin
      s1_sample_q <= sat;
      s1_out_q    <= cfg_i.mute ? '0 : sat;
      s1_last_q   <= last_in_chunk_i;
    end
  end

endmodule

@@ sv/msgcr_queue.sv @@
// Short queue between front end and back end.
// Depends on msgcr_pkg for depth.
module msgcr_queue #(
  parameter int WIDTH = 73
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0]             mem_q [msgcr_pkg::QDEPTH];
  logic [msgcr_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [msgcr_pkg::QPTR_W:0]   cnt_q;
  logic                         do_push, do_pop;

  assign full_o  = cnt_q == (msgcr_pkg::QPTR_W + 1)'(msgcr_pkg::QDEPTH);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + msgcr_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + msgcr_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (msgcr_pkg::QPTR_W + 1)'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - (msgcr_pkg::QPTR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ sv/msgcr_back.sv @@
// Back end: bit-serial divide and square root for the chunk RMS, plus output register.
// Depends on msgcr_pkg; drains msgcr_queue.
module msgcr_back #(
  parameter int CNT_W = 13,
  parameter int SUM_W = 43
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_empty_i,
  output logic                                q_pop_o,
  input  logic [msgcr_pkg::SAMPLE_W-1:0]      q_sample_i,
  input  logic                                q_last_i,
  input  logic [SUM_W-1:0]                    q_sum_i,
  input  logic [CNT_W-1:0]                    q_count_i,
  input  logic                                pop_i,
  output logic                                empty_o,
  output logic signed [msgcr_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic [msgcr_pkg::ROOT_W-1:0]        rms_level_o,
  output logic                                rms_valid_o
);

  localparam int DVD_W = SUM_W + msgcr_pkg::FRAC_SHIFT;
  localparam int IT_W  = $clog2(DVD_W + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_SQRT = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [IT_W-1:0]                iter_q, iter_d;
  logic                           out_valid_q, out_valid_d;
  logic                           slot_free;
  logic                           load_plain, load_rms, start;

  logic [DVD_W-1:0]               dvd_q;
  logic [CNT_W-1:0]               dvs_q;
  logic [CNT_W-1:0]               drem_q;
  logic [msgcr_pkg::Q_W-1:0]      quot_q;
  logic [CNT_W:0]                 drem_sh;
  logic                           dge;
  logic [msgcr_pkg::Q_W-1:0]      quot_next;

  logic [msgcr_pkg::RAD_W-1:0]    rad_q;
  logic [msgcr_pkg::SQ_REM_W-1:0] srem_q;
  logic [msgcr_pkg::ROOT_W-1:0]   root_q;
  logic [msgcr_pkg::SQ_REM_W+1:0] srem_sh;
  logic [msgcr_pkg::SQ_REM_W+1:0] trial;
  logic                           sge;

  logic [msgcr_pkg::SAMPLE_W-1:0] held_sample_q;
  logic [msgcr_pkg::SAMPLE_W-1:0] out_sample_q;
  logic [msgcr_pkg::ROOT_W-1:0]   out_rms_q;
  logic                           out_rvalid_q;

  assign slot_free = !out_valid_q || pop_i;

  // Restoring divide, one quotient bit per cycle.
  assign drem_sh   = {drem_q, dvd_q[DVD_W-1]};
  assign dge       = drem_sh >= {1'b0, dvs_q};
  assign quot_next = {quot_q[msgcr_pkg::Q_W-2:0], dge};

  // Digit-by-digit square root, one root bit per cycle.
  assign srem_sh = {srem_q, rad_q[msgcr_pkg::RAD_W-1 -: 2]};
  assign trial   = (msgcr_pkg::SQ_REM_W + 2)'({root_q, 2'b01});
  assign sge     = srem_sh >= trial;

  always_comb begin
    state_d    = state_q;
    iter_d     = iter_q;
    q_pop_o    = 1'b0;
    load_plain = 1'b0;
    load_rms   = 1'b0;
    start      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          if (q_last_i) begin
            q_pop_o = 1'b1;
            start   = 1'b1;
            iter_d  = '0;
            state_d = S_DIV;
          end else if (slot_free) begin
            q_pop_o    = 1'b1;
            load_plain = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (iter_q == IT_W'(DVD_W - 1)) begin
          iter_d  = '0;
          state_d = S_SQRT;
        end else begin
          iter_d = iter_q + IT_W'(1);
        end
      end
      S_SQRT: begin
        if (iter_q == IT_W'(msgcr_pkg::ROOT_W - 1)) begin
          state_d = S_OUT;
        end else begin
          iter_d = iter_q + IT_W'(1);
        end
      end
      S_OUT: begin
        if (slot_free) begin
          load_rms = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !pop_i;
    if (load_plain || load_rms) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      dvd_q         <= {q_sum_i, msgcr_pkg::FRAC_SHIFT'(0)};
      dvs_q         <= q_count_i;
      drem_q        <= '0;
      quot_q        <= '0;
      held_sample_q <= q_sample_i;
    end else if (state_q == S_DIV) begin
      dvd_q  <= {dvd_q[DVD_W-2:0], 1'b0};
      drem_q <= dge ? CNT_W'(drem_sh - {1'b0, dvs_q}) : drem_sh[CNT_W-1:0];
      quot_q <= quot_next;
      if (iter_q == IT_W'(DVD_W - 1)) begin
        rad_q  <= msgcr_pkg::RAD_W'(quot_next);
        srem_q <= '0;
        root_q <= '0;
      end
    end else if (state_q == S_SQRT) begin
      rad_q  <= {rad_q[msgcr_pkg::RAD_W-3:0], 2'b00};
      srem_q <= sge ? msgcr_pkg::SQ_REM_W'(srem_sh - trial)
                    : msgcr_pkg::SQ_REM_W'(srem_sh);
      root_q <= {root_q[msgcr_pkg::ROOT_W-2:0], sge};
    end
    if (load_plain) begin
      out_sample_q <= q_sample_i;
      out_rms_q    <= '0;
      out_rvalid_q <= 1'b0;
    end else if (load_rms) begin
      out_sample_q <= held_sample_q;
      out_rms_q    <= root_q;
      out_rvalid_q <= 1'b1;
    end
  end

  assign empty_o      = !out_valid_q;
  assign sample_out_o = out_sample_q;
  assign rms_level_o  = out_rms_q;
  assign rms_valid_o  = out_rvalid_q;

endmodule

@@ sv/msgcr_checker.sv @@
// Port-level checks for the gain and chunk RMS block, bound to its top level.
// Depends on msgcr_pkg and mic_sample_gain_and_chunk_rms_top.
module msgcr_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  empty_o,
  input logic                                  pop_i,
  input logic signed [msgcr_pkg::SAMPLE_W-1:0] sample_out_o,
  input logic [msgcr_pkg::ROOT_W-1:0]          rms_level_o,
  input logic                                  rms_valid_o
);

  // No result is shown while reset is held.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty_o)
    else $error("result shown during reset");

  // A plain sample carries a zero level.
  a_rms_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !rms_valid_o) |-> rms_level_o == '0)
    else $error("level set on a result without rms_valid");

  // The chunk level never exceeds full scale in Q16.8.
  a_rms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && rms_valid_o) |-> rms_level_o <= 24'd8388608)
    else $error("rms level above full scale");

  // A held result stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(sample_out_o)
                              && $stable(rms_level_o) && $stable(rms_valid_o)))
    else $error("result changed while stalled");

endmodule

bind mic_sample_gain_and_chunk_rms_top msgcr_checker u_msgcr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty_o      (empty_o),
  .pop_i        (pop_i),
  .sample_out_o (sample_out_o),
  .rms_level_o  (rms_level_o),
  .rms_valid_o  (rms_valid_o)
);
